// ===== hw/rtl/tpkv_pkg.sv =====
// ----------------------------------------------------------------------------
// tpkv_pkg
// Shared types and constants for the two-pool key/value table.
// ----------------------------------------------------------------------------
`default_nettype none
package tpkv_pkg;
	localparam int PSLOTS = 64;
	localparam int TSLOTS = 32;
	localparam int NAME_BYTES = 8;
	localparam int RW = $clog2(TSLOTS + 1);
	localparam int NS = PSLOTS + TSLOTS;
	localparam int CW = $clog2(NS + 1);
	localparam logic [7:0] TEMP_MARK = 8'h5F;
	localparam logic [7:0] ARCH_MARK = 8'h24;
	localparam logic [7:0] SYM_MARK = 8'h40;

	typedef enum logic [2:0] {
		OP_SET = 3'd0, OP_GET = 3'd1, OP_DEF = 3'd2, OP_UNSET = 3'd3, OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY, ST_DONE} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic        shift;
		logic        clear;
		logic        wr;
		logic        wr_tmp;
		logic [63:0] key;
		logic [63:0] value;
		logic        unset_hit;
		logic        touch;
		logic [RW-1:0] old_rank;
		logic        old_q;
		logic [RW-1:0] new_rank;
		logic        evict;
	} cell_ctl_t;

	// head: word enters the head cell during apply; mark: word is the target
	typedef struct packed {
		logic          head;
		logic [63:0]   key;
		logic [63:0]   value;
		logic [RW-1:0] rank;
		logic          inq;
		logic          mark;
	} cell_data_t;

	function automatic logic [63:0] canon_key(input logic [63:0] k);
		logic [63:0] o;
		logic stop;
		o = '0;
		stop = 1'b0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (k[63-8*i -: 8] == 8'h00)
				stop = 1'b1;
			if (!stop)
				o[63-8*i -: 8] = k[63-8*i -: 8];
		end
		return o;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/tpkv_cell.sv =====
// ----------------------------------------------------------------------------
// tpkv_cell
// One table entry; rotates to its neighbor on shift, adjusts LRU rank on ops.
// ----------------------------------------------------------------------------
`default_nettype none
module tpkv_cell
	import tpkv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctl_t  ctl,
	input  wire cell_data_t din,
	output      cell_data_t dout
);
	logic [63:0] key_q, val_q;
	logic [RW-1:0] rank_q;
	logic inq_q;

	assign dout = '{head: 1'b0, key: key_q, value: val_q, rank: rank_q,
		inq: inq_q, mark: 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0; rank_q <= '0; inq_q <= 1'b0;
		end else if (ctl.clear) begin
			key_q <= '0; rank_q <= '0; inq_q <= 1'b0;
		end else if (ctl.shift) begin
			if (din.mark && ctl.wr) begin
				if (ctl.unset_hit) begin
					key_q <= '0; inq_q <= 1'b0; rank_q <= '0;
				end else begin
					key_q <= ctl.key; inq_q <= ctl.wr_tmp; rank_q <= ctl.new_rank;
				end
			end else begin
				key_q <= din.key; inq_q <= din.inq;
				if (din.head && din.inq && (ctl.unset_hit || ctl.touch || ctl.evict)
						&& ctl.old_q && din.rank > ctl.old_rank)
					rank_q <= din.rank - 1'b1;
				else
					rank_q <= din.rank;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (din.mark && ctl.wr && !ctl.unset_hit)
				val_q <= ctl.value;
			else
				val_q <= din.value;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/two_pool_key_value_table_lru.sv =====
// ----------------------------------------------------------------------------
// two_pool_key_value_table_lru
// Two-pool key/value store, 64 persistent and 32 LRU temporary entries.
// ----------------------------------------------------------------------------
// Entries sit in a ring of 96 cells that rotates one place per cycle during
// scan and apply. An operation takes two full turns (scan, then apply), and
// then done is high for a single cycle; busy stays high from the taken start
// through done, and the next start can be taken only once back in idle. The
// result appears on ok and read_value with done high, cannot be held off, and
// stays there until the next operation completes.
`default_nettype none
module two_pool_key_value_table_lru
	import tpkv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [2:0]  op,
	input  wire logic [63:0] key,
	input  wire logic [63:0] data,
	output      logic        done,
	output      logic        ok,
	output      logic [63:0] read_value
);
	state_t st_q, st_d;
	logic [CW-1:0] cnt_q;
	logic [2:0] op_q;
	logic [63:0] key_q, data_q, hval_q;
	logic tmp_q, spec_q, hit_q, fr_q, vic_q;
	logic [CW-1:0] hpos_q, fpos_q, vpos_q;
	logic [RW-1:0] hrank_q, vrank_q, nq_q;
	logic hq_q, ok_q;
	logic [63:0] rv_q;
	cell_ctl_t ctl;
	cell_data_t ring [NS];
	cell_data_t tail;
	cell_data_t din0;
	logic [63:0] ck;
	logic wrap;
	logic ok_sel, do_wr, do_unset, set_ok;
	logic [CW-1:0] tgt;
	logic [RW-1:0] newr;
	logic match, isfree, inpool;

	assign ck = canon_key(key);
	assign tail = ring[NS-1];
	assign wrap = (cnt_q == CW'(NS - 1));

	// tags: first PSLOTS positions persistent; cell NS-1 outputs the next word
	for (genvar g = 0; g < NS; g++) begin : g_cell
		if (g == 0) begin : g_head
			tpkv_cell u_cell (.clk, .arst_n, .ctl, .din(din0), .dout(ring[g]));
		end else begin : g_body
			tpkv_cell u_cell (.clk, .arst_n, .ctl, .din(ring[g-1]), .dout(ring[g]));
		end
	end

	// word entering cell 0 during apply is tail; mark when its position is target
	always_comb begin
		din0 = tail;
		din0.head = (st_q == ST_APPLY);
		din0.mark = (st_q == ST_APPLY) && ok_sel && (cnt_q == tgt);
	end

	// resolve target
	always_comb begin
		ok_sel = 1'b0; tgt = hpos_q; do_wr = 1'b0; do_unset = 1'b0; set_ok = 1'b0;
		case (op_t'(op_q))
			OP_SET: begin
				if (!spec_q && key_q != '0) begin
					if (hit_q) begin tgt = hpos_q; set_ok = 1'b1; end
					else if (fr_q) begin tgt = fpos_q; set_ok = 1'b1; end
					else if (tmp_q && vic_q) begin tgt = vpos_q; set_ok = 1'b1; end
				end
				ok_sel = set_ok; do_wr = set_ok;
			end
			OP_GET: begin ok_sel = hit_q && tmp_q; do_wr = ok_sel; end
			OP_UNSET: begin ok_sel = hit_q; do_wr = hit_q; do_unset = 1'b1; end
			default: ;
		endcase
	end

	// LRU adjust: touch removes old rank and appends at end
	always_comb begin
		newr = nq_q;
		if (op_q == OP_SET && !hit_q && !fr_q) newr = nq_q - 1'b1;
		else if (hit_q && hq_q) newr = nq_q - 1'b1;
		ctl = '0;
		ctl.shift = (st_q == ST_SCAN) || (st_q == ST_APPLY);
		ctl.clear = (st_q == ST_APPLY) && op_q == OP_CLEAR;
		ctl.wr = do_wr;
		ctl.wr_tmp = tmp_q && !do_unset;
		ctl.key = (op_q == OP_GET) ? key_q : key_q;
		ctl.value = (op_q == OP_GET) ? hval_q : data_q;
		ctl.unset_hit = do_unset && ok_sel && tmp_q;
		ctl.touch = do_wr && !do_unset && tmp_q && (hit_q || (!fr_q && vic_q));
		ctl.old_q = (hit_q && hq_q) || (!hit_q && !fr_q && vic_q);
		ctl.old_rank = hit_q ? hrank_q : vrank_q;
		ctl.new_rank = newr;
		ctl.evict = 1'b0;
		if (do_unset && !tmp_q) ctl.unset_hit = ok_sel;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (start) st_d = ST_SCAN;
			ST_SCAN: if (wrap) st_d = ST_APPLY;
			ST_APPLY: if (wrap) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (st_q != ST_IDLE);
		done = (st_q == ST_DONE);
		ok = ok_q;
		read_value = rv_q;
	end

	// scan: position of tail word is cnt_q (ring starts aligned)
	always_comb begin
		inpool = (cnt_q >= CW'(PSLOTS)) == tmp_q;
		match = inpool && tail.key != '0 && tail.key == key_q;
		isfree = inpool && tail.key == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; cnt_q <= '0; ok_q <= 1'b0; rv_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_SCAN || st_q == ST_APPLY)
				cnt_q <= wrap ? '0 : cnt_q + 1'b1;
			if (st_q == ST_APPLY && wrap) begin
				case (op_t'(op_q))
					OP_SET: begin
						ok_q <= set_ok || (key_q == '0 && !spec_q); rv_q <= '0;
					end
					OP_GET: begin ok_q <= hit_q; rv_q <= hit_q ? hval_q : data_q; end
					OP_DEF, OP_UNSET: begin ok_q <= hit_q; rv_q <= '0; end
					default: begin ok_q <= 1'b0; rv_q <= '0; end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			op_q <= op; key_q <= ck; data_q <= data;
			tmp_q <= ck[63:56] == TEMP_MARK;
			spec_q <= ck[63:56] == ARCH_MARK || ck[63:56] == SYM_MARK;
			hit_q <= 1'b0; fr_q <= 1'b0; vic_q <= 1'b0; nq_q <= '0;
		end else if (st_q == ST_SCAN) begin
			if (tail.inq) nq_q <= nq_q + 1'b1;
			if (!spec_q && key_q != '0) begin
				if (match && !hit_q) begin
					hit_q <= 1'b1; hpos_q <= cnt_q; hval_q <= tail.value;
					hrank_q <= tail.rank; hq_q <= tail.inq;
				end
				if (isfree && !fr_q) begin fr_q <= 1'b1; fpos_q <= cnt_q; end
			end
			if (tail.inq && tail.rank == '0 && !vic_q) begin
				vic_q <= 1'b1; vpos_q <= cnt_q; vrank_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/tpkv_checker.sv =====
// ----------------------------------------------------------------------------
// tpkv_checker
// Port-level checks of the command handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module tpkv_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
endmodule

bind two_pool_key_value_table_lru tpkv_checker u_chk (.clk, .arst_n, .start, .busy,
	.done);
`default_nettype wire
